// ===== hw/rtl/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and helpers of the cyclic ID allocator.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int CIA_ID_SPACE = 4096;

    // Internal ID width: id_limit is 13 bits, so no ID or cursor goes past it.
    localparam int ID_W       = 13;
    localparam int FIELD_W    = 12;
    localparam int BIT_W      = 6;
    localparam int MAP_W      = 64;
    localparam int WORD_W     = ID_W - BIT_W;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_DISABLED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 1'd1;

    localparam logic [ID_W-1:0]    RST_ID_LIMIT = 13'd4096;
    localparam logic [FIELD_W-1:0] RST_FLOOR    = 12'd300;

    typedef struct packed {
        logic [ID_W-1:0]    id_limit;
        logic [FIELD_W-1:0] reserved_floor;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_word;
        logic [MAP_W-1:0]  wr_data;
        logic [WORD_W-1:0] rd_word;
    } t_mem_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_hit;

    // Lowest set bit of a map word.
    function automatic t_hit first_set(input logic [MAP_W-1:0] vec);
        t_hit h;
        h.found = 1'b0;
        h.idx   = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (vec[b]) begin
                h.found = 1'b1;
                h.idx   = BIT_W'(b);
            end
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/cia_if.sv =====
// ----------------------------------------------------------------------------
// cia_if
// Valid/ready channels of the cyclic ID allocator: request, response, config.
// ----------------------------------------------------------------------------
interface cia_req_if import cia_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [FIELD_W-1:0] release_id;

    modport source (output valid, output action, output release_id, input ready);
    modport sink   (input valid, input action, input release_id, output ready);
endinterface

interface cia_rsp_if import cia_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [FIELD_W-1:0] granted_id;

    modport source (output valid, output status, output granted_id, input ready);
    modport sink   (input valid, input status, input granted_id, output ready);
endinterface

interface cia_cfg_if import cia_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cia_map_mem.sv =====
// ----------------------------------------------------------------------------
// cia_map_mem
// Used-map storage: 64-bit words, one write and one registered read a cycle,
// with a reset-cleared valid bit per word so unwritten words read as free.
// ----------------------------------------------------------------------------
module cia_map_mem import cia_pkg::*; #(
    parameter int ID_SPACE = CIA_ID_SPACE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_req         i_req,
    output logic [MAP_W-1:0] o_rd_data
);

    localparam int SPACE_CLIP = (ID_SPACE > 8191) ? 8191 : ID_SPACE;
    localparam int NW         = (SPACE_CLIP + MAP_W - 1) / MAP_W;
    localparam int AW         = (NW > 1) ? $clog2(NW) : 1;

    logic [MAP_W-1:0] mem [NW];
    logic [NW-1:0]    r_row_valid;
    logic [MAP_W-1:0] r_q;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_word[AW-1:0]] <= i_req.wr_data;
        end
        r_q <= mem[i_req.rd_word[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_valid[i_req.wr_word[AW-1:0]] <= 1'b1;
            end
            // words past the map read as free; the scan masks them anyway
            r_rd_ok <= ({1'b0, i_req.rd_word} < 8'(NW)) &&
                       r_row_valid[i_req.rd_word[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_ok ? r_q : '0;

endmodule

// ===== hw/rtl/cia_ctrl.sv =====
// ----------------------------------------------------------------------------
// cia_ctrl
// Request sequencer: word-by-word cyclic free-ID scan, free read-modify-write,
// enable flag, cursor and the response register.
// ----------------------------------------------------------------------------
module cia_ctrl import cia_pkg::*; #(
    parameter int ID_SPACE = CIA_ID_SPACE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    cia_req_if.sink          i_req,
    cia_rsp_if.source        o_rsp,
    output t_mem_req         o_mem,
    input  logic [MAP_W-1:0] i_rd_data
);

    localparam int SPACE_CLIP = (ID_SPACE > 8191) ? 8191 : ID_SPACE;
    localparam logic [ID_W-1:0] SPACE_ID = ID_W'(SPACE_CLIP);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_PASS_START = 3'd1;
    localparam logic [2:0] S_SCAN       = 3'd2;
    localparam logic [2:0] S_FREE_WR    = 3'd3;
    localparam logic [2:0] S_RESULT     = 3'd4;

    logic [2:0]         r_state, n_state;
    logic               r_enabled, n_enabled;
    logic [ID_W-1:0]    r_cursor, n_cursor;
    logic [ID_W-1:0]    r_lo, n_lo;
    logic [ID_W-1:0]    r_hi, n_hi;
    logic [ID_W-1:0]    r_start, n_start;
    logic [ID_W-1:0]    r_base, n_base;
    logic               r_pass, n_pass;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [BIT_W-1:0]   r_rel_bit, n_rel_bit;
    logic [ST_W-1:0]    r_status, n_status;
    logic [ID_W-1:0]    r_grant, n_grant;
    logic               r_out_valid, n_out_valid;
    logic [ST_W-1:0]    r_out_status, n_out_status;
    logic [FIELD_W-1:0] r_out_id, n_out_id;

    logic               accept;
    logic [ID_W-1:0]    floor_id, lo_c, hi_c;
    logic [ID_W-1:0]    last_id;
    logic [MAP_W-1:0]   low_mask, high_mask, cand;
    logic               first_word, last_word;
    t_hit               hit;
    logic [ID_W-1:0]    hit_id;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);

    // search bounds from config and cursor
    always_comb begin
        floor_id = (i_cfg.reserved_floor != '0) ? {1'b0, i_cfg.reserved_floor}
                                                : ID_W'(1);
        lo_c     = (r_cursor > floor_id) ? floor_id : ID_W'(1);
        hi_c     = (i_cfg.id_limit < SPACE_ID) ? i_cfg.id_limit : SPACE_ID;
    end

    // candidate bits of the word under evaluation
    always_comb begin
        last_id    = r_hi - ID_W'(1);
        first_word = (r_word == r_base[ID_W-1:BIT_W]);
        last_word  = (r_word == last_id[ID_W-1:BIT_W]);
        low_mask   = {MAP_W{1'b1}} << r_base[BIT_W-1:0];
        high_mask  = {MAP_W{1'b1}} >> (BIT_W'(MAP_W - 1) - last_id[BIT_W-1:0]);
        cand       = ~i_rd_data & (first_word ? low_mask : {MAP_W{1'b1}})
                                & (last_word ? high_mask : {MAP_W{1'b1}});
        hit        = first_set(cand);
        hit_id     = {r_word, hit.idx};
    end

    always_comb begin
        n_state      = r_state;
        n_enabled    = r_enabled;
        n_cursor     = r_cursor;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_start      = r_start;
        n_base       = r_base;
        n_pass       = r_pass;
        n_word       = r_word;
        n_rel_bit    = r_rel_bit;
        n_status     = r_status;
        n_grant      = r_grant;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;

        o_mem.wr_en   = 1'b0;
        o_mem.wr_word = r_word;
        o_mem.wr_data = i_rd_data;
        o_mem.rd_word = r_word;

        unique case (r_state)
            S_IDLE: begin
                o_mem.rd_word = {1'b0, i_req.release_id[FIELD_W-1:BIT_W]};
                if (accept) begin
                    n_status = ST_OK;
                    n_grant  = '0;
                    n_state  = S_RESULT;
                    unique case (i_req.action)
                        ACT_ALLOC: begin
                            if (!r_enabled) begin
                                n_status = ST_DISABLED;
                            end else begin
                                n_lo    = lo_c;
                                n_hi    = hi_c;
                                n_start = (r_cursor > lo_c) ? r_cursor : lo_c;
                                n_base  = (r_cursor > lo_c) ? r_cursor : lo_c;
                                n_pass  = 1'b0;
                                n_state = S_PASS_START;
                            end
                        end
                        ACT_FREE: begin
                            if ((i_req.release_id != '0) &&
                                ({1'b0, i_req.release_id} < SPACE_ID)) begin
                                n_word    = {1'b0, i_req.release_id[FIELD_W-1:BIT_W]};
                                n_rel_bit = i_req.release_id[BIT_W-1:0];
                                n_state   = S_FREE_WR;
                            end
                        end
                        ACT_DISABLE: begin
                            n_enabled = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_PASS_START: begin
                o_mem.rd_word = r_base[ID_W-1:BIT_W];
                if (r_base >= r_hi) begin
                    // empty pass: wrap once to the lower bound, else give up
                    if (!r_pass && (r_start > r_lo)) begin
                        n_pass = 1'b1;
                        n_base = r_lo;
                    end else begin
                        n_status = ST_NO_SPACE;
                        n_grant  = '0;
                        n_state  = S_RESULT;
                    end
                end else begin
                    n_word  = r_base[ID_W-1:BIT_W];
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // prefetch the next word while this one is evaluated
                o_mem.rd_word = r_word + WORD_W'(1);
                if (hit.found) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_data = i_rd_data | (MAP_W'(1) << hit.idx);
                    n_cursor      = hit_id + ID_W'(1);
                    n_status      = ST_OK;
                    n_grant       = hit_id;
                    n_state       = S_RESULT;
                end else if (last_word) begin
                    if (!r_pass && (r_start > r_lo)) begin
                        n_pass  = 1'b1;
                        n_base  = r_lo;
                        n_state = S_PASS_START;
                    end else begin
                        n_status = ST_NO_SPACE;
                        n_grant  = '0;
                        n_state  = S_RESULT;
                    end
                end else begin
                    n_word = r_word + WORD_W'(1);
                end
            end

            S_FREE_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_data = i_rd_data & ~(MAP_W'(1) << r_rel_bit);
                n_state       = S_RESULT;
            end

            S_RESULT: begin
                // hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_id     = r_grant[FIELD_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b1;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enabled   <= n_enabled;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_start      <= n_start;
        r_base       <= n_base;
        r_pass       <= n_pass;
        r_word       <= n_word;
        r_rel_bit    <= n_rel_bit;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.granted_id = r_out_id;

endmodule

// ===== hw/rtl/cyclic_id_allocator_unit.sv =====
// Allocate: scans the used map word by word, one word a cycle, and wraps once to the
//   lower bound; up to two passes over min(id_limit, ID_SPACE)/64 words.
// Free: one read-modify-write of the map word.
// One request at a time; the response register lets the next request in.
// Synchronous active-low reset: map reads as all free at once (per-word valid
//   bits), cursor 0, allocation enabled, id_limit 4096, reserved_floor 300.
// ----------------------------------------------------------------------------
// cyclic_id_allocator_unit
// Cyclic ID allocator with a reserved wrap floor: config registers, sequencer
// and used-map memory.
// ----------------------------------------------------------------------------
module cyclic_id_allocator_unit import cia_pkg::*; #(
    parameter int ID_SPACE = CIA_ID_SPACE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cia_req_if.sink   i_req,
    cia_rsp_if.source o_rsp,
    cia_cfg_if.sink   i_cfg
);

    t_cfg             r_cfg;
    t_mem_req         mem_req;
    logic [MAP_W-1:0] rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_limit       <= RST_ID_LIMIT;
            r_cfg.reserved_floor <= RST_FLOOR;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ID_LIMIT: r_cfg.id_limit       <= i_cfg.data;
                CFG_FLOOR:    r_cfg.reserved_floor <= i_cfg.data[FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cia_ctrl #(
        .ID_SPACE (ID_SPACE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem     (mem_req),
        .i_rd_data (rd_data)
    );

    cia_map_mem #(
        .ID_SPACE (ID_SPACE)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

// ===== bench/cyclic_id_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cyclic_id_allocator_unit_test
// Self-checking bench for the cyclic ID allocator. A queue-fed driver offers
// allocate, free and disable requests under several limit and floor settings.
// A monitor compares every response with a bit-true prediction of the
// used-map, cursor and enable flag. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module cyclic_id_allocator_unit_test;
    import cia_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FIELD_W-1:0] release_id;
    } t_id_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] granted_id;
    } t_id_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cia_req_if req_if ();
    cia_rsp_if rsp_if ();
    cia_cfg_if cfg_if ();

    cyclic_id_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // Predicted allocator state.
    bit                 id_used [CIA_ID_SPACE];
    int unsigned        alloc_cursor;
    bit                 alloc_open;
    logic [ID_W-1:0]    cur_limit;
    logic [FIELD_W-1:0] cur_floor;

    t_id_req req_beats_q[$];
    t_id_rsp owed_rsp_q[$];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    function automatic int unsigned first_free(int unsigned lo, int unsigned hi);
        for (int unsigned id = lo; id < hi; id++) begin
            if (!id_used[id]) return id;
        end
        return 0;
    endfunction

    function automatic t_id_rsp apply_request(t_id_req r);
        t_id_rsp     o;
        int unsigned flo, lo, hi, start, id;
        o.status     = ST_OK;
        o.granted_id = '0;
        case (r.action)
            ACT_ALLOC: begin
                if (!alloc_open) begin
                    o.status = ST_DISABLED;
                end else begin
                    flo   = (cur_floor != 0) ? cur_floor : 1;
                    lo    = (alloc_cursor > flo) ? flo : 1;
                    hi    = (cur_limit < CIA_ID_SPACE) ? cur_limit : CIA_ID_SPACE;
                    start = (alloc_cursor > lo) ? alloc_cursor : lo;
                    id    = first_free(start, hi);
                    // wrap back to the lower bound
                    if (id == 0 && start > lo) id = first_free(lo, hi);
                    if (id == 0) begin
                        o.status = ST_NO_SPACE;
                    end else begin
                        id_used[id]  = 1'b1;
                        alloc_cursor = id + 1;
                        o.granted_id = FIELD_W'(id);
                    end
                end
            end
            ACT_FREE: begin
                if (r.release_id != 0) id_used[r.release_id] = 1'b0;
            end
            ACT_DISABLE: begin
                alloc_open = 1'b0;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_id_req random_beat(int unsigned span, bit with_disable);
        t_id_req     b;
        int unsigned pick;
        pick         = $urandom_range(99);
        b.release_id = FIELD_W'($urandom_range(4095));
        if (pick < 55) begin
            b.action = ACT_ALLOC;
        end else if (pick < 90) begin
            b.action = ACT_FREE;
            // mostly aim frees inside the live range so they hit used IDs
            if (pick < 85) b.release_id = FIELD_W'($urandom_range(span - 1));
        end else if (pick < 95 || !with_disable) begin
            b.action = ACT_UNUSED;
        end else begin
            b.action = ACT_DISABLE;
        end
        return b;
    endfunction

    task automatic push_beat(logic [ACT_W-1:0] act, logic [FIELD_W-1:0] id);
        t_id_req b;
        b.action     = act;
        b.release_id = id;
        req_beats_q.push_back(b);
    endtask

    // Wait until every request is accepted and answered, then let the block settle.
    task automatic drain();
        while (req_beats_q.size() != 0 || owed_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_ID_LIMIT) cur_limit = value[ID_W-1:0];
        else                     cur_floor = value[FIELD_W-1:0];
    endtask

    // Request driver: hold the beat until accepted, then offer the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                owed_rsp_q.push_back(apply_request(req_beats_q.pop_front()));
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_if.valid      <= 1'b1;
                    req_if.action     <= req_beats_q[0].action;
                    req_if.release_id <= req_beats_q[0].release_id;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and ready generator.
    always @(posedge i_clk) begin
        t_id_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_rsp_q.size() == 0) begin
                    $display("%0t: response with none outstanding: status %0d granted_id %0d",
                             $time, rsp_if.status, rsp_if.granted_id);
                    fail_count = fail_count + 1;
                end else begin
                    want = owed_rsp_q.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp_if.status);
                        fail_count = fail_count + 1;
                    end
                    if (rsp_if.granted_id !== want.granted_id) begin
                        $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                                 $time, want.granted_id, rsp_if.granted_id);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (hold_served != hold_asked) begin
                hold_served  <= hold_asked;
                hold_left    <= HOLD_LEN;
                rsp_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("cyclic_id_allocator_unit_test: errors");
        $finish;
    end

    initial begin
        int          send_mode [4];
        int          stall_mode [4];
        int unsigned span, lim, flo;
        send_mode  = '{0, 61, 0, 25};
        stall_mode = '{0, 0, 61, 25};

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_ALLOC;
        req_if.release_id = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_ID_LIMIT;
        cfg_if.data       = '0;
        foreach (id_used[k]) id_used[k] = 1'b0;
        alloc_cursor = 0;
        alloc_open   = 1'b1;
        cur_limit    = RST_ID_LIMIT;
        cur_floor    = RST_FLOOR;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: basic allocate, free of zero and of unused IDs, unused action.
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_ALLOC, 12'd4095);
        push_beat(ACT_FREE, 12'd0);
        push_beat(ACT_FREE, 12'd4095);
        push_beat(ACT_FREE, 12'd1);
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_UNUSED, 12'd4095);
        drain();
        // limit beyond the map
        write_reg(CFG_ID_LIMIT, 13'd8191);
        push_beat(ACT_ALLOC, 12'd0);
        drain();
        // tiny range: grant, then exhaust with wrap to the floor
        write_reg(CFG_ID_LIMIT, 13'd6);
        write_reg(CFG_FLOOR, 13'd2);
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_ALLOC, 12'd0);
        drain();
        // zero floor acts as one
        write_reg(CFG_FLOOR, 13'd0);
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_FREE, 12'd3);
        push_beat(ACT_ALLOC, 12'd0);
        drain();
        // empty range: lower bound at the limit
        write_reg(CFG_ID_LIMIT, 13'd2);
        write_reg(CFG_FLOOR, 13'd2);
        push_beat(ACT_ALLOC, 12'd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                lim = 4096;
                flo = 4095;
            end else if (ph == 1) begin
                lim = 2;
                flo = 1;
            end else begin
                lim = ($urandom_range(3) == 0) ? $urandom_range(4096, 200)
                                               : $urandom_range(200, 2);
                flo = $urandom_range((lim + 20 > 4095) ? 4095 : lim + 20, 1);
            end
            write_reg(CFG_ID_LIMIT, CFG_DATA_W'(lim));
            write_reg(CFG_FLOOR, CFG_DATA_W'(flo));
            send_idle_pct = send_mode[ph % 4];
            rsp_stall_pct = stall_mode[ph % 4];
            span = (lim < CIA_ID_SPACE) ? lim : CIA_ID_SPACE;
            // long receiver hold-off while requests keep coming
            if (ph == 2) hold_asked++;
            for (int n = 0; n < 70; n++) begin
                req_beats_q.push_back(random_beat(span, 1'b0));
                // pause the sender until every response is in
                if (ph == 5 && n == 34) drain();
            end
            drain();
        end

        // Disable last: allocation stays closed until reset, frees still apply.
        write_reg(CFG_ID_LIMIT, 13'd64);
        write_reg(CFG_FLOOR, 13'd10);
        send_idle_pct = send_mode[3];
        rsp_stall_pct = stall_mode[3];
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_DISABLE, 12'd0);
        push_beat(ACT_ALLOC, 12'd0);
        push_beat(ACT_FREE, 12'd1);
        push_beat(ACT_FREE, 12'd0);
        push_beat(ACT_UNUSED, 12'd0);
        push_beat(ACT_DISABLE, 12'd4095);
        push_beat(ACT_ALLOC, 12'd0);
        for (int n = 0; n < 20; n++) req_beats_q.push_back(random_beat(64, 1'b1));
        drain();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && owed_rsp_q.size() == 0) begin
            $display("cyclic_id_allocator_unit_test: clean");
        end else begin
            $display("cyclic_id_allocator_unit_test: errors");
        end
        $finish;
    end

endmodule
